### sv/ape_pkg.sv
`default_nettype none

package ape_pkg;

  // Easing curve codes carried with each item
  typedef enum logic [2:0] {
    MODE_LINEAR    = 3'd0,
    MODE_QUADRATIC = 3'd1,
    MODE_CUBIC     = 3'd2,
    MODE_PULSE     = 3'd3,
    MODE_OVERSHOOT = 3'd4,
    MODE_BLINK     = 3'd5
  } mode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LENGTH   = 2'd0;
  localparam cfg_idx_t CFG_REVERSED = 2'd1;
  localparam cfg_idx_t CFG_ENABLED  = 2'd2;

  // Fixed point scale used while building the overshoot curve
  localparam int SINE_QS = 28;
  localparam int BLINK_STEPS = 20;

  // Overshoot curve: sin(0.7*pi*p) * 1.236, angle and gain as decimal ratios
  localparam longint SINE_ANGLE_NUM = 64'sd2199113;
  localparam longint SINE_ANGLE_DEN = 64'sd1000000;
  localparam longint SINE_GAIN_NUM  = 64'sd1236;
  localparam longint SINE_GAIN_DEN  = 64'sd1000;

endpackage

`default_nettype wire

### sv/animation_progress_easing_core.sv
// Animation progress and easing core.
//
// Input channel (in_valid/in_ready): elapsed_ms and ease_mode, one item per
// handshake. Output channel (out_valid/out_ready): fraction (eased, Q1.15),
// progress (linear, clamped, after reversal) and active, one item per input.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 length_ms, 1 reversed, 2 enabled); other indexes are ignored. Write
// configuration only while no item is in flight.
//
// The pipeline has one entry stage, FRAC_BITS restoring-divider stages (one
// quotient bit each), a progress stage, two multiplier/table stages and the
// output register. Throughput is one item per cycle while the output is not
// stalled.
//
// The whole pipeline advances together: when out_valid is high and
// out_ready low, every stage holds and in_ready drops; nothing is dropped or
// repeated. Reset clears all stage valid bits and sets length_ms 0,
// reversed 0, enabled 1.
`default_nettype none

module animation_progress_easing_core
  import ape_pkg::*;
#(
  parameter int TIME_BITS        = 24,
  parameter int FRAC_BITS        = 15,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_BITS-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [TIME_BITS-1:0] elapsed_ms,
  input  wire logic [2:0]           ease_mode,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [15:0]               fraction,
  output logic [15:0]               progress,
  output logic                      active
);

  localparam int FW = FRAC_BITS + 1;
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = FRAC_BITS + IW;
  localparam int BW = FRAC_BITS + 6;
  localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FW-1:0] HALF = ONE >> 1;
  localparam logic [PW-1:0] DEPTH_C = PW'(SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(SINE_TABLE_DEPTH);
  localparam logic [BW-1:0] BLINK_C = BW'(BLINK_STEPS);

  // Scales for the overshoot table, all fixed at elaboration
  localparam longint SINE_DEN  = SINE_ANGLE_DEN * longint'(SINE_TABLE_DEPTH);
  localparam longint SINE_SDEN = SINE_GAIN_DEN << SINE_QS;
  localparam longint SINE_ONE  = 64'sd1 << FRAC_BITS;

  // Overshoot curve, constant table; sine from a 13-term Taylor series in Q28
  logic [FW-1:0] over_tab [0:SINE_TABLE_DEPTH];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam longint X   = (((SINE_ANGLE_NUM * longint'(k)) << SINE_QS)
                              + (SINE_DEN >> 1)) / SINE_DEN;
    localparam longint X2  = (X * X) >> SINE_QS;
    localparam longint T1  = ((X * X2) >> SINE_QS) / 64'sd6;
    localparam longint T2  = ((T1 * X2) >> SINE_QS) / 64'sd20;
    localparam longint T3  = ((T2 * X2) >> SINE_QS) / 64'sd42;
    localparam longint T4  = ((T3 * X2) >> SINE_QS) / 64'sd72;
    localparam longint T5  = ((T4 * X2) >> SINE_QS) / 64'sd110;
    localparam longint T6  = ((T5 * X2) >> SINE_QS) / 64'sd156;
    localparam longint T7  = ((T6 * X2) >> SINE_QS) / 64'sd210;
    localparam longint T8  = ((T7 * X2) >> SINE_QS) / 64'sd272;
    localparam longint T9  = ((T8 * X2) >> SINE_QS) / 64'sd342;
    localparam longint T10 = ((T9 * X2) >> SINE_QS) / 64'sd420;
    localparam longint T11 = ((T10 * X2) >> SINE_QS) / 64'sd506;
    localparam longint T12 = ((T11 * X2) >> SINE_QS) / 64'sd600;
    localparam longint SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9
                             + T10 - T11 + T12;
    localparam longint S   = (SUM < 64'sd0) ? 64'sd0 : SUM;
    localparam longint E   = (S * SINE_GAIN_NUM * SINE_ONE + (SINE_SDEN >> 1))
                             / SINE_SDEN;
    assign over_tab[k] = FW'(E);
  end

  // Configuration registers
  logic [TIME_BITS-1:0] length_ms;
  logic                 reversed;
  logic                 enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_ms <= '0;
      reversed  <= 1'b0;
      enabled   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LENGTH:   length_ms <= cfg_data;
        CFG_REVERSED: reversed  <= cfg_data[0];
        CFG_ENABLED:  enabled   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Global advance: all stages move when the output is free
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Divider pipeline; index 0 is the entry register
  logic                 dv_valid [0:FRAC_BITS];
  logic [TIME_BITS-1:0] dv_rem   [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] dv_quo   [0:FRAC_BITS];
  mode_t                dv_mode  [0:FRAC_BITS];
  logic                 dv_full  [0:FRAC_BITS];
  logic                 dv_act   [0:FRAC_BITS];

  // Entry: saturation and activity decided up front
  logic entry_below;
  assign entry_below = elapsed_ms < length_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0]  <= elapsed_ms;
      dv_quo[0]  <= '0;
      dv_mode[0] <= mode_t'(ease_mode);
      dv_full[0] <= !enabled || (length_ms == '0) || !entry_below;
      dv_act[0]  <= enabled && entry_below;
    end
  end

  // One quotient bit per stage
  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_div
    logic [TIME_BITS:0] r2;
    logic [TIME_BITS:0] diff;
    logic               take;
    assign r2   = {dv_rem[s], 1'b0};
    assign diff = r2 - {1'b0, length_ms};
    assign take = r2 >= {1'b0, length_ms};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[s+1] <= dv_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[s+1]  <= take ? diff[TIME_BITS-1:0] : r2[TIME_BITS-1:0];
        dv_quo[s+1]  <= {dv_quo[s][FRAC_BITS-2:0], take};
        dv_mode[s+1] <= dv_mode[s];
        dv_full[s+1] <= dv_full[s];
        dv_act[s+1]  <= dv_act[s];
      end
    end
  end

  // Progress stage: saturate and reverse
  logic          p_valid;
  logic [FW-1:0] p_frac;
  mode_t         p_mode;
  logic          p_act;
  logic [FW-1:0] p_pre;
  assign p_pre = dv_full[FRAC_BITS] ? ONE : {1'b0, dv_quo[FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= dv_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_frac <= reversed ? (ONE - p_pre) : p_pre;
      p_mode <= dv_mode[FRAC_BITS];
      p_act  <= dv_act[FRAC_BITS];
    end
  end

  // Stage 1: square, table lookup, pulse and blink
  logic [PW-1:0] pos;
  logic [IW-1:0] t_idx;
  logic [IW-1:0] t_idx_hi;
  logic [BW-1:0] blink_pos;
  logic          t_end;
  assign pos       = PW'(p_frac) * DEPTH_C;
  assign t_idx     = pos[PW-1:FRAC_BITS];
  assign t_end     = t_idx >= LAST_IDX;
  assign t_idx_hi  = t_end ? LAST_IDX : t_idx + IW'(1);
  assign blink_pos = BW'(p_frac) * BLINK_C;

  logic                 m1_valid;
  logic [FW-1:0]        m1_p;
  mode_t                m1_mode;
  logic                 m1_act;
  logic [2*FW-1:0]      m1_sq;
  logic [FW-1:0]        m1_pulse;
  logic                 m1_blink;
  logic [FW-1:0]        m1_ta;
  logic [FW-1:0]        m1_tb;
  logic [FRAC_BITS-1:0] m1_f;
  logic                 m1_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_p     <= p_frac;
      m1_mode  <= p_mode;
      m1_act   <= p_act;
      m1_sq    <= (2*FW)'(p_frac) * (2*FW)'(p_frac);
      m1_pulse <= (p_frac < HALF) ? (p_frac << 1) : ((ONE - p_frac) << 1);
      m1_blink <= blink_pos[FRAC_BITS];
      m1_ta    <= over_tab[t_idx];
      m1_tb    <= over_tab[t_idx_hi];
      m1_f     <= pos[FRAC_BITS-1:0];
      m1_end   <= t_end;
    end
  end

  // Stage 2: cube product and interpolation product
  logic [FW-1:0] m1_quad;
  logic          m1_up;
  logic [FW-1:0] m1_diff;
  assign m1_quad = m1_sq[FRAC_BITS +: FW];
  assign m1_up   = m1_tb >= m1_ta;
  assign m1_diff = m1_up ? (m1_tb - m1_ta) : (m1_ta - m1_tb);

  logic                    m2_valid;
  logic [FW-1:0]           m2_p;
  mode_t                   m2_mode;
  logic                    m2_act;
  logic [FW-1:0]           m2_quad;
  logic [2*FW-1:0]         m2_cube;
  logic [FW-1:0]           m2_pulse;
  logic                    m2_blink;
  logic [FW-1:0]           m2_ta;
  logic                    m2_up;
  logic [FW+FRAC_BITS-1:0] m2_ov;
  logic                    m2_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_p     <= m1_p;
      m2_mode  <= m1_mode;
      m2_act   <= m1_act;
      m2_quad  <= m1_quad;
      m2_cube  <= (2*FW)'(m1_quad) * (2*FW)'(m1_p);
      m2_pulse <= m1_pulse;
      m2_blink <= m1_blink;
      m2_ta    <= m1_ta;
      m2_up    <= m1_up;
      m2_ov    <= (FW+FRAC_BITS)'(m1_diff) * (FW+FRAC_BITS)'(m1_f);
      m2_end   <= m1_end;
    end
  end

  // Curve select
  logic [FW-1:0] ov_step;
  logic [FW-1:0] ov_val;
  logic [FW-1:0] sel;
  assign ov_step = m2_ov[FRAC_BITS +: FW];

  always_comb begin
    if (m2_end) begin
      ov_val = over_tab[SINE_TABLE_DEPTH];
    end else if (m2_up) begin
      ov_val = m2_ta + ov_step;
    end else begin
      ov_val = m2_ta - ov_step;
    end
  end

  always_comb begin
    unique case (m2_mode)
      MODE_QUADRATIC: sel = m2_quad;
      MODE_CUBIC:     sel = m2_cube[FRAC_BITS +: FW];
      MODE_PULSE:     sel = m2_pulse;
      MODE_OVERSHOOT: sel = ov_val;
      MODE_BLINK:     sel = m2_blink ? ONE : '0;
      default:        sel = m2_p;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fraction <= 16'(sel);
      progress <= 16'(m2_p);
      active   <= m2_act;
    end
  end

  // An active item can never have taken the saturated path
  a_act_not_full: assert property (@(posedge clk) disable iff (rst)
    dv_valid[0] && dv_act[0] |-> !dv_full[0])
    else $error("active item marked saturated");

  // Linear progress stays within one
  a_p_range: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> p_frac <= ONE)
    else $error("progress above one");

  // A stalled item in the last curve stage stays put
  a_m2_hold: assert property (@(posedge clk) disable iff (rst)
    m2_valid && !adv |=> m2_valid && $stable(m2_p))
    else $error("item lost during stall");

endmodule

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench;
  import ape_pkg::*;

  localparam longint unsigned ONE = 64'd1 << 15;
  localparam int TAB_DEPTH = 256;
  localparam int PIPE_LAT = 25;
  localparam int LONG_HOLD = 300;
  localparam logic [2:0] MODE_UNUSED6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED7 = 3'd7;
  localparam cfg_idx_t CFG_UNUSED = 2'd3;
  localparam logic [23:0] TMAX = 24'hFFFFFF;

  typedef struct {
    logic [15:0] fraction;
    logic [15:0] progress;
    logic        active;
  } ease_result_t;

  typedef struct {
    logic [23:0] len;
    logic        rev;
    logic        en;
    logic [23:0] elapsed;
    logic [2:0]  mode;
    logic        typed;
    logic [15:0] fraction;
    logic [15:0] progress;
    logic        active;
  } stim_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  cfg_idx_t    cfg_index = CFG_LENGTH;
  logic [23:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [23:0] elapsed_ms = 0;
  logic [2:0]  ease_mode = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [15:0] fraction;
  logic [15:0] progress;
  logic        active;

  // configuration copy held by the predictor
  logic [23:0] cur_len = 0;
  logic        cur_rev = 0;
  logic        cur_en = 1;

  longint unsigned over_curve [0:TAB_DEPTH];
  ease_result_t pending_results[$];
  int  errors = 0;
  bit  calm = 0;
  bit  hold_req = 0;

  always #5 clk = ~clk;

  animation_progress_easing_core dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .elapsed_ms(elapsed_ms), .ease_mode(ease_mode),
    .out_valid(out_valid), .out_ready(out_ready),
    .fraction(fraction), .progress(progress), .active(active)
  );

  // sine in Q28 from a truncated Taylor series, clamped at zero
  function automatic longint unsigned sine_fixed(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    x2 = (x * x) >> 28;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 28) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return (acc < 0) ? 0 : longint'(acc);
  endfunction

  function automatic ease_result_t ease_predict(logic [23:0] el, logic [2:0] m);
    longint unsigned p;
    longint unsigned fr;
    longint unsigned pos;
    longint unsigned i;
    longint unsigned f;
    longint unsigned a;
    longint unsigned b;
    ease_result_t r;
    r.active = 0;
    if (!cur_en) begin
      p = cur_rev ? 0 : ONE;
    end else begin
      if (cur_len == 0) begin
        p = ONE;
      end else begin
        p = ({40'd0, el} * ONE) / {40'd0, cur_len};
        if (p > ONE) p = ONE;
      end
      if (cur_rev) p = ONE - p;
      r.active = (el < cur_len);
    end
    case (m)
      MODE_QUADRATIC: fr = (p * p) >> 15;
      MODE_CUBIC:     fr = (((p * p) >> 15) * p) >> 15;
      MODE_PULSE:     fr = (p < ONE / 2) ? 2 * p : 2 * (ONE - p);
      MODE_OVERSHOOT: begin
        pos = p * TAB_DEPTH;
        i = pos >> 15;
        f = pos & (ONE - 1);
        if (i >= TAB_DEPTH) begin
          fr = over_curve[TAB_DEPTH];
        end else begin
          a = over_curve[i];
          b = over_curve[i + 1];
          fr = (b >= a) ? a + (((b - a) * f) >> 15) : a - (((a - b) * f) >> 15);
        end
      end
      MODE_BLINK:     fr = (((p * 20) >> 15) & 1) ? ONE : 0;
      default:        fr = p;
    endcase
    r.fraction = fr[15:0];
    r.progress = p[15:0];
    return r;
  endfunction

  // three register writes back to back, plus an optional write to the unused index
  task automatic apply_config(logic [23:0] len, logic rev, logic en, bit stray);
    cfg_wr_en <= 1;
    cfg_index <= CFG_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cur_len = len;
    cfg_index <= CFG_REVERSED;
    cfg_data  <= {23'($urandom), rev};
    @(posedge clk);
    cur_rev = rev;
    cfg_index <= CFG_ENABLED;
    cfg_data  <= {23'($urandom), en};
    @(posedge clk);
    cur_en = en;
    if (stray) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= 24'($urandom);
      @(posedge clk);
    end
    cfg_wr_en <= 0;
  endtask

  // stop offering and wait until every expected item has come out
  task automatic wait_drained();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // offer one item after a gap; returns at the edge it is taken
  task automatic send_item(logic [23:0] el, logic [2:0] m, bit typed, ease_result_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1;
    elapsed_ms <= el;
    ease_mode  <= m;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? want : ease_predict(el, m));
  endtask

  function automatic logic [23:0] pick_elapsed();
    int unsigned top;
    case ($urandom_range(0, 3))
      0: begin
        top = int'(cur_len) + int'(cur_len) / 4 + 1;
        pick_elapsed = (top > TMAX) ? 24'($urandom) : 24'($urandom_range(0, top));
      end
      1: pick_elapsed = 24'($urandom);
      2: pick_elapsed = cur_len + 24'($urandom_range(0, 2)) - 24'd1;
      default: pick_elapsed = 24'($urandom_range(0, cur_len));
    endcase
  endfunction

  // result side: random stalls, one long hold-off when asked
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        stall = LONG_HOLD;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item fraction=%0d progress=%0d active=%0d",
                 $time, fraction, progress, active);
      end else begin
        ease_result_t w;
        w = pending_results.pop_front();
        if (fraction !== w.fraction) begin
          errors++;
          $display("%0t: fraction expected %0d got %0d", $time, w.fraction, fraction);
        end
        if (progress !== w.progress) begin
          errors++;
          $display("%0t: progress expected %0d got %0d", $time, w.progress, progress);
        end
        if (active !== w.active) begin
          errors++;
          $display("%0t: active expected %0d got %0d", $time, w.active, active);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t rows[$];
    ease_result_t want;
    logic [23:0] len;
    longint unsigned x;
    for (int k = 0; k <= TAB_DEPTH; k++) begin
      x = ((64'd2199113 * k << 28) + 64'd128000000) / 64'd256000000;
      over_curve[k] = (sine_fixed(x) * 1236 * ONE + ((64'd1000 << 28) / 2)) /
                      (64'd1000 << 28);
    end

    rows = '{
      '{0, 0, 1, 0, MODE_LINEAR, 1, 32768, 32768, 0},
      '{0, 0, 1, 12345, MODE_UNUSED7, 1, 32768, 32768, 0},
      '{1000, 0, 1, 0, MODE_LINEAR, 1, 0, 0, 1},
      '{1000, 0, 1, 500, MODE_LINEAR, 1, 16384, 16384, 1},
      '{1000, 0, 1, 1000, MODE_LINEAR, 1, 32768, 32768, 0},
      '{1000, 0, 1, TMAX, MODE_LINEAR, 1, 32768, 32768, 0},
      '{1000, 0, 1, 500, MODE_PULSE, 1, 32768, 16384, 1},
      '{1000, 0, 1, 250, MODE_QUADRATIC, 0, 0, 0, 0},
      '{1000, 0, 1, 250, MODE_CUBIC, 0, 0, 0, 0},
      '{1000, 0, 1, 250, MODE_PULSE, 0, 0, 0, 0},
      '{1000, 0, 1, 250, MODE_OVERSHOOT, 0, 0, 0, 0},
      '{1000, 0, 1, 1000, MODE_OVERSHOOT, 0, 0, 0, 0},
      '{1000, 0, 1, 75, MODE_BLINK, 0, 0, 0, 0},
      '{1000, 0, 1, 250, MODE_UNUSED6, 0, 0, 0, 0},
      '{1000, 1, 1, 0, MODE_LINEAR, 1, 32768, 32768, 1},
      '{1000, 1, 1, 1000, MODE_LINEAR, 1, 0, 0, 0},
      '{TMAX, 0, 1, TMAX - 1, MODE_CUBIC, 0, 0, 0, 0},
      '{1, 0, 1, 0, MODE_OVERSHOOT, 1, 0, 0, 1},
      '{1, 0, 1, TMAX, MODE_OVERSHOOT, 0, 0, 0, 0},
      '{1000, 0, 0, 300, MODE_LINEAR, 1, 32768, 32768, 0},
      '{1000, 1, 0, 300, MODE_LINEAR, 1, 0, 0, 0},
      '{0, 1, 1, 5, MODE_LINEAR, 1, 0, 0, 0}
    };

    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table; reconfigure whenever a row asks for other settings
    foreach (rows[r]) begin
      if (rows[r].len != cur_len || rows[r].rev != cur_rev || rows[r].en != cur_en) begin
        wait_drained();
        apply_config(rows[r].len, rows[r].rev, rows[r].en, 0);
      end
      want.fraction = rows[r].fraction;
      want.progress = rows[r].progress;
      want.active   = rows[r].active;
      send_item(rows[r].elapsed, rows[r].mode, rows[r].typed, want);
    end

    // random phases, each started from an idle block
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case ($urandom_range(0, 4))
        0: len = 0;
        1: len = TMAX;
        2: len = 24'($urandom);
        default: len = 24'($urandom_range(1, 2000));
      endcase
      if (ph == 1) len = 1;
      apply_config(len, 1'($urandom), ($urandom_range(0, 4) != 0), ph == 0);
      calm = (ph == 2);
      if (ph == 3) hold_req = 1;
      repeat (75) begin
        send_item(pick_elapsed(),
                  ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5)),
                  0, want);
      end
    end
    calm = 0;

    wait_drained();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/ape_pkg.sv
sv/animation_progress_easing_core.sv
dv/testbench.sv
